// File: design/lccf_pkg.sv
package lccf_pkg;

	localparam int CHANNELS = 4;
	localparam int CH_W = 2;
	localparam int LEVEL_W = 10;
	localparam logic [LEVEL_W-1:0] LEVEL_MAX = 10'd999;
	localparam int NUM_CH_W = 3;

	localparam int IDX_W = 4;
	localparam logic [IDX_W-1:0] IDX_START = 4'd0;
	localparam logic [IDX_W-1:0] IDX_ZERO = 4'd1;
	localparam logic [IDX_W-1:0] IDX_CHAN = 4'd2;
	localparam logic [IDX_W-1:0] IDX_FUNC = 4'd3;
	localparam logic [IDX_W-1:0] IDX_HUND = 4'd4;
	localparam logic [IDX_W-1:0] IDX_TENS = 4'd5;
	localparam logic [IDX_W-1:0] IDX_ONES = 4'd6;
	localparam logic [IDX_W-1:0] IDX_SUM_HI = 4'd7;
	localparam logic [IDX_W-1:0] IDX_SUM_LO = 4'd8;
	localparam logic [IDX_W-1:0] IDX_CR = 4'd9;
	localparam logic [IDX_W-1:0] IDX_LF = 4'd10;

	localparam logic [7:0] CHAR_AT = 8'h40;
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_F = 8'h46;
	localparam logic [7:0] CHAR_A = 8'h41;
	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [7:0] CHAR_LF = 8'h0A;

	// Byte sum of '@', '0', 'F' and the four '0' bases of the digit characters.
	localparam logic [7:0] SUM_BASE = 8'((32'h40 + 32'h46 + 5 * 32'h30) % 256);

	localparam logic STATUS_PASS = 1'b0;
	localparam logic STATUS_INVALID = 1'b1;

	localparam logic CMD_STORE = 1'b0;
	localparam logic CMD_TOGGLE = 1'b1;

	localparam logic REG_ENABLE = 1'b0;
	localparam logic REG_NUM_CHANNELS = 1'b1;

	typedef struct packed {
		logic cmd;
		logic [CH_W-1:0] channel;
		logic [LEVEL_W-1:0] level;
		logic turn_on;
	} lccf_in_t;

	typedef struct packed {
		logic status;
		logic byte_valid;
		logic [7:0] data_byte;
		logic last_of_run;
	} lccf_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_DIG1,
		ST_DIG2,
		ST_SUM,
		ST_SEND
	} lccf_state_t;

	typedef struct packed {
		logic load_in;
		logic store_lvl;
		logic dig1;
		logic dig2;
		logic sum;
		logic emit_single;
		logic single_status;
		logic emit_byte;
		logic [IDX_W-1:0] byte_idx;
	} lccf_ctl_t;

	typedef struct packed {
		logic disabled;
		logic invalid;
		logic toggle;
	} lccf_stat_t;

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] r;
		if (nib < 4'd10) begin
			r = CHAR_ZERO + {4'd0, nib};
		end else begin
			r = CHAR_A + {4'd0, nib} - 8'd10;
		end
		return r;
	endfunction

endpackage

// File: design/lccf_ctrl.sv
module lccf_ctrl
	import lccf_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input lccf_stat_t stat,
	output lccf_ctl_t ctl
);

	lccf_state_t state_q, state_d;
	logic [IDX_W-1:0] byte_cnt_q, byte_cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			byte_cnt_q <= IDX_START;
		end else begin
			state_q <= state_d;
			byte_cnt_q <= byte_cnt_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		byte_cnt_d = byte_cnt_q;
		ctl = '0;
		ctl.byte_idx = byte_cnt_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					ctl.load_in = 1'b1;
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				state_d = ST_IDLE;
				if (stat.disabled) begin
					ctl.emit_single = 1'b1;
					ctl.single_status = STATUS_PASS;
				end else if (stat.invalid) begin
					ctl.emit_single = 1'b1;
					ctl.single_status = STATUS_INVALID;
				end else if (!stat.toggle) begin
					ctl.store_lvl = 1'b1;
					ctl.emit_single = 1'b1;
					ctl.single_status = STATUS_PASS;
				end else begin
					state_d = ST_DIG1;
				end
			end
			ST_DIG1: begin
				ctl.dig1 = 1'b1;
				state_d = ST_DIG2;
			end
			ST_DIG2: begin
				ctl.dig2 = 1'b1;
				state_d = ST_SUM;
			end
			ST_SUM: begin
				ctl.sum = 1'b1;
				byte_cnt_d = IDX_START;
				state_d = ST_SEND;
			end
			ST_SEND: begin
				ctl.emit_byte = 1'b1;
				if (byte_cnt_q == IDX_LF) begin
					byte_cnt_d = IDX_START;
					state_d = ST_IDLE;
				end else begin
					byte_cnt_d = byte_cnt_q + 4'd1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	a_start_eval: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == ST_EVAL))
		else $error("accepted command did not enter evaluation");

	a_eval_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EVAL) |=> (state_q == ST_IDLE || state_q == ST_DIG1))
		else $error("evaluation left to an unexpected state");

	a_send_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEND && byte_cnt_q != IDX_LF) |=>
		(state_q == ST_SEND && byte_cnt_q == $past(byte_cnt_q) + 4'd1))
		else $error("frame byte counter skipped");

	a_send_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEND && byte_cnt_q == IDX_LF) |=> (state_q == ST_IDLE))
		else $error("frame did not end after the last byte");

endmodule

// File: design/lccf_dp.sv
module lccf_dp
	import lccf_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input lccf_in_t item,
	input logic enable,
	input logic [NUM_CH_W-1:0] num_channels,
	input lccf_ctl_t ctl,
	output lccf_stat_t stat,
	output logic result_valid,
	output lccf_out_t result
);

	lccf_in_t item_q;
	logic [LEVEL_W-1:0] levels_q [CHANNELS];
	logic [3:0] hund_q, tens_q, ones_q;
	logic [6:0] rem_q;
	logic [7:0] sum_q;
	logic result_valid_q;
	lccf_out_t result_q;

	logic [LEVEL_W-1:0] send;
	logic [15:0] hund_prod;
	logic [3:0] hund;
	logic [13:0] tens_prod;
	logic [3:0] tens;
	logic [LEVEL_W-1:0] store_val;
	logic [7:0] frame_byte;

	assign stat.disabled = !enable;
	assign stat.invalid = ({1'b0, item_q.channel} >= num_channels) ||
		(32'(item_q.channel) >= CHANNELS);
	assign stat.toggle = (item_q.cmd == CMD_TOGGLE);

	assign send = item_q.turn_on ? levels_q[item_q.channel] : '0;
	// Hundreds by x*41/4096 and tens by x*103/1024 are exact over the digit ranges.
	assign hund_prod = 16'(send) * 16'd41;
	assign hund = hund_prod[15:12];
	assign tens_prod = 14'(rem_q) * 14'd103;
	assign tens = tens_prod[13:10];
	assign store_val = (item_q.level > LEVEL_MAX) ? LEVEL_MAX : item_q.level;

	always_ff @(posedge clk) begin
		if (ctl.load_in) begin
			item_q <= item;
		end
		if (ctl.dig1) begin
			hund_q <= hund;
			rem_q <= 7'(send - 10'(hund) * 10'd100);
		end
		if (ctl.dig2) begin
			tens_q <= tens;
			ones_q <= 4'(rem_q - 7'(tens) * 7'd10);
		end
		if (ctl.sum) begin
			sum_q <= SUM_BASE + {6'd0, item_q.channel} + {4'd0, hund_q} +
				{4'd0, tens_q} + {4'd0, ones_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				levels_q[i] <= '0;
			end
		end else if (ctl.store_lvl) begin
			levels_q[item_q.channel] <= store_val;
		end
	end

	always_comb begin
		unique case (ctl.byte_idx)
			IDX_START: frame_byte = CHAR_AT;
			IDX_ZERO: frame_byte = CHAR_ZERO;
			IDX_CHAN: frame_byte = CHAR_ZERO + {6'd0, item_q.channel};
			IDX_FUNC: frame_byte = CHAR_F;
			IDX_HUND: frame_byte = CHAR_ZERO + {4'd0, hund_q};
			IDX_TENS: frame_byte = CHAR_ZERO + {4'd0, tens_q};
			IDX_ONES: frame_byte = CHAR_ZERO + {4'd0, ones_q};
			IDX_SUM_HI: frame_byte = hex_char(sum_q[7:4]);
			IDX_SUM_LO: frame_byte = hex_char(sum_q[3:0]);
			IDX_CR: frame_byte = CHAR_CR;
			IDX_LF: frame_byte = CHAR_LF;
			default: frame_byte = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= ctl.emit_single || ctl.emit_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit_single) begin
			result_q.status <= ctl.single_status;
			result_q.byte_valid <= 1'b0;
			result_q.data_byte <= '0;
			result_q.last_of_run <= 1'b1;
		end else if (ctl.emit_byte) begin
			result_q.status <= STATUS_PASS;
			result_q.byte_valid <= 1'b1;
			result_q.data_byte <= frame_byte;
			result_q.last_of_run <= (ctl.byte_idx == IDX_LF);
		end
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

endmodule

// File: design/light_channel_command_framer_top.sv
// A command is taken when start is high and busy is low; busy then stays high until it is done.
// Store, invalid-channel and disabled commands give one word, set in evaluation and registered.
// A valid toggle gives eleven frame words on consecutive cycles, after the evaluation state
// and the digit and checksum steps; the byte sequencer counts out the frame bytes.
// Words cannot be held off by the receiver.
// Reset clears all stored levels to zero, sets enable to 1 and the channel count to 4.
module light_channel_command_framer_top
	import lccf_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input lccf_in_t item,
	output logic result_valid,
	output lccf_out_t result,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	logic enable_q;
	logic [NUM_CH_W-1:0] num_channels_q;
	logic cfg_wr;
	lccf_ctl_t ctl;
	lccf_stat_t stat;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
			num_channels_q <= 3'd4;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_ENABLE) begin
				enable_q <= pwdata[0];
			end else begin
				num_channels_q <= pwdata[NUM_CH_W-1:0];
			end
		end
	end

	always_comb begin
		if (paddr[2] == REG_NUM_CHANNELS) begin
			prdata = {29'd0, num_channels_q};
		end else begin
			prdata = {31'd0, enable_q};
		end
	end

	lccf_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.stat(stat),
		.ctl(ctl)
	);

	lccf_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.enable(enable_q),
		.num_channels(num_channels_q),
		.ctl(ctl),
		.stat(stat),
		.result_valid(result_valid),
		.result(result)
	);

endmodule

// File: sim/tb_light_channel_command_framer_top.sv
module tb_light_channel_command_framer_top;
	timeunit 1ns;
	timeprecision 1ps;

	import lccf_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int TAIL_CYCLES = 24;
	localparam int RANDOM_WORDS = 400;
	localparam int FRAME_BYTES = 11;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	lccf_in_t item = '0;
	logic result_valid;
	lccf_out_t result;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	logic [LEVEL_W-1:0] lvl_store [CHANNELS] = '{default: '0};
	logic en_reg = 1'b1;
	logic [NUM_CH_W-1:0] nch_reg = 3'd4;
	lccf_out_t due_words [$];
	int mismatches = 0;
	int cycles = 0;
	bit no_gaps = 1'b0;

	light_channel_command_framer_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.result_valid(result_valid),
		.result(result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAIL light_channel_command_framer_top");
			$finish;
		end
	end

	always @(posedge clk) begin
		lccf_out_t want;
		if (arst_n && result_valid) begin
			if (due_words.size() == 0) begin
				mismatches++;
				$display({"%0t: unexpected word, expected none, ",
					"got status=%0d valid=%0d byte=%h last=%0d"},
					$time, result.status, result.byte_valid, result.data_byte,
					result.last_of_run);
			end else begin
				want = due_words.pop_front();
				if (want.status !== result.status || want.byte_valid !== result.byte_valid ||
						want.data_byte !== result.data_byte ||
						want.last_of_run !== result.last_of_run) begin
					mismatches++;
					$display({"%0t: expected status=%0d valid=%0d byte=%h last=%0d, ",
						"got status=%0d valid=%0d byte=%h last=%0d"},
						$time, want.status, want.byte_valid, want.data_byte,
						want.last_of_run, result.status, result.byte_valid,
						result.data_byte, result.last_of_run);
				end
			end
		end
	end

	function automatic logic [7:0] nib_ascii(logic [3:0] n);
		logic [7:0] c;
		if (n > 4'd9) begin
			c = CHAR_A + ({4'd0, n} - 8'd10);
		end else begin
			c = CHAR_ZERO + {4'd0, n};
		end
		return c;
	endfunction

	function automatic void push_word(logic st, logic bv, logic [7:0] b, logic last);
		lccf_out_t w;
		w.status = st;
		w.byte_valid = bv;
		w.data_byte = b;
		w.last_of_run = last;
		due_words.push_back(w);
	endfunction

	// Updates the channel levels and queues the words this command should produce.
	function automatic void compute_answer(lccf_in_t w);
		logic [7:0] frame [FRAME_BYTES];
		logic [7:0] csum;
		int lvl;
		int i;
		if (!en_reg) begin
			push_word(STATUS_PASS, 1'b0, 8'h00, 1'b1);
		end else if ({1'b0, w.channel} >= nch_reg) begin
			push_word(STATUS_INVALID, 1'b0, 8'h00, 1'b1);
		end else if (w.cmd == CMD_STORE) begin
			lvl_store[w.channel] = (w.level > LEVEL_MAX) ? LEVEL_MAX : w.level;
			push_word(STATUS_PASS, 1'b0, 8'h00, 1'b1);
		end else begin
			lvl = w.turn_on ? int'(lvl_store[w.channel]) : 0;
			frame[0] = CHAR_AT;
			frame[1] = CHAR_ZERO;
			frame[2] = CHAR_ZERO + {6'd0, w.channel};
			frame[3] = CHAR_F;
			frame[4] = CHAR_ZERO + 8'(lvl / 100);
			frame[5] = CHAR_ZERO + 8'((lvl / 10) % 10);
			frame[6] = CHAR_ZERO + 8'(lvl % 10);
			csum = 8'h00;
			for (i = 0; i < 7; i++) begin
				csum = csum + frame[i];
			end
			frame[7] = nib_ascii(csum[7:4]);
			frame[8] = nib_ascii(csum[3:0]);
			frame[9] = CHAR_CR;
			frame[10] = CHAR_LF;
			for (i = 0; i < FRAME_BYTES; i++) begin
				push_word(STATUS_PASS, 1'b1, frame[i], i == FRAME_BYTES - 1);
			end
		end
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 45) begin
			return 0;
		end
		if (r < 85) begin
			return $urandom_range(1, 3);
		end
		if (r < 97) begin
			return $urandom_range(4, 16);
		end
		return $urandom_range(20, 60);
	endfunction

	function automatic lccf_in_t cmd_word(logic c, logic [CH_W-1:0] ch,
			logic [LEVEL_W-1:0] lvl, logic on);
		lccf_in_t w;
		w.cmd = c;
		w.channel = ch;
		w.level = lvl;
		w.turn_on = on;
		return w;
	endfunction

	// Start stays high from one accepted command to the next when no gap is wanted.
	task automatic send_word(lccf_in_t w);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		item <= w;
		do @(posedge clk); while (busy);
		compute_answer(w);
	endtask

	task automatic drain();
		if (start) begin
			start <= 1'b0;
			@(posedge clk);
		end
		while (due_words.size() != 0 || busy) @(posedge clk);
	endtask

	task automatic apb_write(logic idx, logic [31:0] val);
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == REG_ENABLE) begin
			en_reg = val[0];
		end else begin
			nch_reg = val[NUM_CH_W-1:0];
		end
	endtask

	task automatic set_config(logic en, logic [NUM_CH_W-1:0] nch);
		drain();
		psel <= 1'b1;
		pwrite <= 1'b1;
		apb_write(REG_ENABLE, {31'd0, en});
		apb_write(REG_NUM_CHANNELS, {29'd0, nch});
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic test_reset_state();
		send_word(cmd_word(CMD_TOGGLE, 2'd0, 10'd0, 1'b1));
		send_word(cmd_word(CMD_TOGGLE, 2'd3, 10'd1023, 1'b0));
		send_word(cmd_word(CMD_TOGGLE, 2'd2, 10'd0, 1'b1));
	endtask

	task automatic test_level_extremes();
		send_word(cmd_word(CMD_STORE, 2'd0, 10'd1023, 1'b1));
		send_word(cmd_word(CMD_STORE, 2'd1, 10'd999, 1'b0));
		send_word(cmd_word(CMD_STORE, 2'd2, 10'd1000, 1'b1));
		send_word(cmd_word(CMD_STORE, 2'd3, 10'h155, 1'b0));
		send_word(cmd_word(CMD_TOGGLE, 2'd0, 10'd0, 1'b1));
		send_word(cmd_word(CMD_TOGGLE, 2'd1, 10'h2AA, 1'b1));
		send_word(cmd_word(CMD_TOGGLE, 2'd2, 10'd0, 1'b1));
		send_word(cmd_word(CMD_TOGGLE, 2'd3, 10'd0, 1'b1));
		send_word(cmd_word(CMD_STORE, 2'd3, 10'd0, 1'b0));
		send_word(cmd_word(CMD_TOGGLE, 2'd1, 10'd0, 1'b0));
	endtask

	task automatic test_channel_count();
		set_config(1'b1, 3'd1);
		send_word(cmd_word(CMD_TOGGLE, 2'd1, 10'd0, 1'b1));
		send_word(cmd_word(CMD_STORE, 2'd3, 10'd512, 1'b0));
		send_word(cmd_word(CMD_TOGGLE, 2'd0, 10'd0, 1'b1));
		set_config(1'b1, 3'd3);
		send_word(cmd_word(CMD_STORE, 2'd3, 10'd1, 1'b0));
		send_word(cmd_word(CMD_TOGGLE, 2'd2, 10'd0, 1'b1));
		set_config(1'b1, 3'd4);
		send_word(cmd_word(CMD_TOGGLE, 2'd3, 10'd0, 1'b1));
	endtask

	task automatic test_disabled();
		set_config(1'b0, 3'd4);
		send_word(cmd_word(CMD_STORE, 2'd0, 10'd5, 1'b0));
		send_word(cmd_word(CMD_TOGGLE, 2'd0, 10'd0, 1'b1));
		send_word(cmd_word(CMD_STORE, 2'd2, 10'd77, 1'b1));
		set_config(1'b1, 3'd4);
		send_word(cmd_word(CMD_TOGGLE, 2'd0, 10'd0, 1'b1));
	endtask

	task automatic test_random();
		lccf_in_t w;
		logic en;
		logic [NUM_CH_W-1:0] nch;
		int counted;
		int n;
		counted = 0;
		while (counted < RANDOM_WORDS) begin
			en = ($urandom_range(0, 7) != 0);
			nch = 3'($urandom_range(1, 4));
			no_gaps = ($urandom_range(0, 3) == 0);
			set_config(en, nch);
			n = en ? $urandom_range(30, 70) : $urandom_range(4, 10);
			repeat (n) begin
				w.cmd = 1'($urandom_range(0, 1));
				if ($urandom_range(0, 99) < 85) begin
					w.channel = 2'($urandom_range(0, nch - 1));
				end else begin
					w.channel = 2'($urandom_range(0, 3));
				end
				if ($urandom_range(0, 7) == 0) begin
					case ($urandom_range(0, 3))
						0: w.level = 10'd0;
						1: w.level = 10'd999;
						2: w.level = 10'd1000;
						default: w.level = 10'd1023;
					endcase
				end else begin
					w.level = 10'($urandom_range(0, 1023));
				end
				w.turn_on = 1'($urandom_range(0, 1));
				if ($urandom_range(0, 39) == 0) begin
					drain();
				end
				send_word(w);
			end
			if (en) begin
				counted += n;
			end
		end
		no_gaps = 1'b0;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_level_extremes();
		test_channel_count();
		test_disabled();
		test_random();
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && due_words.size() == 0) begin
			$display("PASS light_channel_command_framer_top");
		end else begin
			$display("FAIL light_channel_command_framer_top");
		end
		$finish;
	end

endmodule
